[hw/rtl/mfd_pkg.sv]
// Shared types and constants for the meter frame deframer.
// No dependencies; imported by meter_frame_deframer.
package mfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 9;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [OFFSET_W-1:0] ADDR_FIRST    = 9'd1;
   localparam logic [OFFSET_W-1:0] ADDR_LAST     = 9'd6;
   localparam logic [OFFSET_W-1:0] START2_OFFSET = 9'd7;
   localparam logic [OFFSET_W-1:0] CTRL_OFFSET   = 9'd8;
   localparam logic [OFFSET_W-1:0] LEN_OFFSET    = 9'd9;
   localparam logic [OFFSET_W-1:0] DATA_OFFSET   = 9'd10;

   localparam logic [BYTE_W-1:0] START_RESET = 8'h68;
   localparam logic [BYTE_W-1:0] END_RESET   = 8'h16;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END   = 1'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDR   = 3'd0,
      KIND_CTRL   = 3'd1,
      KIND_LEN    = 3'd2,
      KIND_DATA   = 3'd3,
      KIND_ACCEPT = 3'd4,
      KIND_ERROR  = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_START  = 3'd1,
      ST_NO_START2 = 3'd2,
      ST_LENGTH    = 3'd3,
      ST_NO_END    = 3'd4,
      ST_CHECKSUM  = 3'd5
   } status_type;

   typedef enum logic [5:0] {
      PH_HUNT   = 6'b000001,
      PH_HEADER = 6'b000010,
      PH_DATA   = 6'b000100,
      PH_CHECK  = 6'b001000,
      PH_END    = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] field_index;
      status_type        status;
      logic [BYTE_W-1:0] consumed;
   } record_type;

endpackage

[hw/rtl/meter_frame_deframer.sv]
// Meter frame deframer: splits buffer bytes into address, control, length and data
// records and closes each frame with an accept or error record.
// Depends on mfd_pkg.
//
//  channel | ports        | payload
//  --------+--------------+-----------------------------------------------
//  request | req_t*       | tdata: byte_in; tlast: buffer_last
//  result  | rsp_t*       | tdata: value, field_index, status, consumed;
//          |              | tuser: kind
//  config  | csr_*        | index 0 start_byte, index 1 end_byte
//
// One request per cycle while req_tready is high; its record, if any, appears on rsp the next cycle.
// A single result register separates the sides: a request is taken whenever that
// register is empty or is being drained in the same cycle.
// Synchronous active-high reset returns the parser to hunting and restores the
// delimiter defaults.
module meter_frame_deframer
   import mfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] byte_in
   input  logic                 req_tlast,   // buffer_last
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [7:0] value, [15:8] field_index,
                                             // [18:16] status, [26:19] consumed, zero
   output logic [KIND_W-1:0]    rsp_tuser,   // [2:0] kind
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   logic [BYTE_W-1:0]   start_ff, end_ff;
   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   pos_ff, pos_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [BYTE_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic                bad_ff, bad_in;
   logic                rsp_valid_ff;
   record_type          rsp_ff;
   record_type          rec;
   logic                rec_valid;
   logic                take;
   logic [BYTE_W-1:0]   pos_inc;
   logic [OFFSET_W-1:0] off_inc;
   logic [BYTE_W-1:0]   sum_add;
   logic [OFFSET_W:0]   data_end;
   logic                outcome;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign pos_inc    = (pos_ff == 8'hFF) ? pos_ff : pos_ff + 8'd1;
   assign off_inc    = off_ff + 9'd1;
   assign sum_add    = sum_ff + req_tdata;
   assign data_end   = {1'b0, DATA_OFFSET} + {2'b00, len_ff};

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      off_in    = off_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      bad_in    = bad_ff;
      rec_valid = 1'b0;
      outcome   = 1'b0;
      rec       = '{kind: KIND_ADDR, value: '0, field_index: '0, status: ST_OK,
                    consumed: '0};
      if (take) begin
         pos_in = pos_inc;
         case (phase_ff)
            PH_HUNT: begin
               if (req_tdata == start_ff) begin
                  sum_in   = req_tdata;
                  off_in   = ADDR_FIRST;
                  phase_in = PH_HEADER;
               end
               if (req_tlast) begin
                  rec_valid  = 1'b1;
                  rec.kind   = KIND_ERROR;
                  rec.status = (req_tdata == start_ff) ? ST_LENGTH : ST_NO_START;
               end
            end
            PH_HEADER: begin
               if (off_ff == START2_OFFSET && req_tdata != start_ff) begin
                  rec_valid  = 1'b1;
                  rec.kind   = KIND_ERROR;
                  rec.status = ST_NO_START2;
                  outcome    = 1'b1;
               end else begin
                  if (off_ff inside {[ADDR_FIRST:ADDR_LAST]}) begin
                     rec_valid       = 1'b1;
                     rec.kind        = KIND_ADDR;
                     rec.value       = req_tdata;
                     rec.field_index = BYTE_W'(off_ff - ADDR_FIRST);
                  end else if (off_ff == CTRL_OFFSET) begin
                     rec_valid = 1'b1;
                     rec.kind  = KIND_CTRL;
                     rec.value = req_tdata;
                  end else if (off_ff == LEN_OFFSET) begin
                     rec_valid = 1'b1;
                     rec.kind  = KIND_LEN;
                     rec.value = req_tdata;
                     len_in    = req_tdata;
                  end
                  sum_in = sum_add;
                  off_in = off_inc;
                  if (off_ff >= LEN_OFFSET) begin
                     phase_in = (req_tdata != 8'd0) ? PH_DATA : PH_CHECK;
                  end
                  if (req_tlast) begin
                     rec_valid       = 1'b1;
                     rec.kind        = KIND_ERROR;
                     rec.value       = '0;
                     rec.field_index = '0;
                     rec.status      = ST_LENGTH;
                  end
               end
            end
            PH_DATA: begin
               rec_valid       = 1'b1;
               rec.kind        = KIND_DATA;
               rec.value       = req_tdata;
               rec.field_index = BYTE_W'(off_ff - DATA_OFFSET);
               sum_in          = sum_add;
               off_in          = off_inc;
               if ({1'b0, off_inc} >= data_end) begin
                  phase_in = PH_CHECK;
               end
               if (req_tlast) begin
                  rec.kind        = KIND_ERROR;
                  rec.value       = '0;
                  rec.field_index = '0;
                  rec.status      = ST_LENGTH;
               end
            end
            PH_CHECK: begin
               bad_in   = (req_tdata != sum_ff);
               off_in   = off_inc;
               phase_in = PH_END;
               if (req_tlast) begin
                  rec_valid  = 1'b1;
                  rec.kind   = KIND_ERROR;
                  rec.status = ST_LENGTH;
               end
            end
            PH_END: begin
               rec_valid = 1'b1;
               outcome   = 1'b1;
               if (req_tdata != end_ff) begin
                  rec.kind   = KIND_ERROR;
                  rec.status = ST_NO_END;
               end else if (bad_ff) begin
                  rec.kind   = KIND_ERROR;
                  rec.status = ST_CHECKSUM;
               end else begin
                  rec.kind     = KIND_ACCEPT;
                  rec.value    = len_ff;
                  rec.consumed = pos_inc;
               end
            end
            default: begin
            end
         endcase
         if (req_tlast) begin
            phase_in = PH_HUNT;
            pos_in   = '0;
            off_in   = '0;
            len_in   = '0;
            sum_in   = '0;
            bad_in   = 1'b0;
         end else if (outcome) begin
            phase_in = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RESET;
         end_ff       <= END_RESET;
         phase_ff     <= PH_HUNT;
         pos_ff       <= '0;
         off_ff       <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_START: start_ff <= csr_wdata;
               CSR_END:   end_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         off_ff   <= off_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         bad_ff   <= bad_in;
         if (req_tready) begin
            rsp_valid_ff <= rec_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && rec_valid) begin
         rsp_ff <= rec;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'd0, rsp_ff.consumed, rsp_ff.status, rsp_ff.field_index,
                        rsp_ff.value};

endmodule

[dv/tb_top.sv]
// Testbench for meter_frame_deframer: directed and random receive buffers with a
// byte-level parser model and an in-order record scoreboard.
// Depends on mfd_pkg and the meter_frame_deframer RTL.
module tb_top;
   import mfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 250000;
   localparam int HOLD_CYCLES  = 200;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic [KIND_W-1:0]    rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr   = CSR_START;
   logic [BYTE_W-1:0]    csr_wdata  = '0;

   meter_frame_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   logic [7:0] cfg_start = START_RESET;
   logic [7:0] cfg_end   = END_RESET;
   phase_type  m_phase   = PH_HUNT;
   logic [7:0] m_pos     = '0;
   logic [8:0] m_off     = '0;
   logic [7:0] m_len     = '0;
   logic [7:0] m_sum     = '0;
   bit         m_cks_bad = 1'b0;

   record_type pending_records[$];
   logic [7:0] rx_buf[$];

   int src_idle_pct = 18;
   int snk_idle_pct = 18;
   int hold_reqs    = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int cycle_cnt    = 0;
   int n_sent       = 0;
   int n_field      = 0;
   int n_accept     = 0;
   int n_error      = 0;
   int n_err        = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- parser model
   function automatic record_type mk_rec(input kind_type k, input logic [7:0] v,
                                         input logic [7:0] idx, input status_type s,
                                         input logic [7:0] c);
      record_type r;
      r.kind        = k;
      r.value       = v;
      r.field_index = idx;
      r.status      = s;
      r.consumed    = c;
      return r;
   endfunction

   function automatic void clear_parser();
      m_phase   = PH_HUNT;
      m_pos     = '0;
      m_off     = '0;
      m_len     = '0;
      m_sum     = '0;
      m_cks_bad = 1'b0;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                     output record_type rec);
      bit         hit;
      bit         done;
      logic [8:0] off;
      hit  = 1'b0;
      done = 1'b0;
      rec  = '0;
      off  = m_off;
      if (m_pos != 8'hFF)
         m_pos++;
      case (m_phase)
         PH_HUNT: begin
            if (b == cfg_start) begin
               m_sum   = b;
               m_off   = 9'd1;
               m_phase = PH_HEADER;
               if (is_last) begin
                  rec = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_LENGTH, 8'd0);
                  hit = 1'b1;
               end
            end else if (is_last) begin
               rec = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_NO_START, 8'd0);
               hit = 1'b1;
            end
         end
         PH_HEADER: begin
            if (off == START2_OFFSET && b != cfg_start) begin
               rec  = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_NO_START2, 8'd0);
               hit  = 1'b1;
               done = 1'b1;
            end else begin
               if (off >= ADDR_FIRST && off <= ADDR_LAST) begin
                  rec = mk_rec(KIND_ADDR, b, 8'(off - ADDR_FIRST), ST_OK, 8'd0);
                  hit = 1'b1;
               end else if (off == CTRL_OFFSET) begin
                  rec = mk_rec(KIND_CTRL, b, 8'd0, ST_OK, 8'd0);
                  hit = 1'b1;
               end else if (off == LEN_OFFSET) begin
                  m_len = b;
                  rec   = mk_rec(KIND_LEN, b, 8'd0, ST_OK, 8'd0);
                  hit   = 1'b1;
               end
               m_sum = m_sum + b;
               m_off = off + 9'd1;
               if (off >= LEN_OFFSET) begin
                  if (m_len != 8'd0)
                     m_phase = PH_DATA;
                  else
                     m_phase = PH_CHECK;
               end
               if (is_last) begin
                  rec = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_LENGTH, 8'd0);
                  hit = 1'b1;
               end
            end
         end
         PH_DATA: begin
            rec   = mk_rec(KIND_DATA, b, 8'(off - DATA_OFFSET), ST_OK, 8'd0);
            hit   = 1'b1;
            m_sum = m_sum + b;
            m_off = off + 9'd1;
            if (m_off >= DATA_OFFSET + {1'b0, m_len})
               m_phase = PH_CHECK;
            if (is_last)
               rec = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_LENGTH, 8'd0);
         end
         PH_CHECK: begin
            m_cks_bad = (b != m_sum);
            m_off     = off + 9'd1;
            m_phase   = PH_END;
            if (is_last) begin
               rec = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_LENGTH, 8'd0);
               hit = 1'b1;
            end
         end
         PH_END: begin
            if (b != cfg_end)
               rec = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_NO_END, 8'd0);
            else if (m_cks_bad)
               rec = mk_rec(KIND_ERROR, 8'd0, 8'd0, ST_CHECKSUM, 8'd0);
            else
               rec = mk_rec(KIND_ACCEPT, m_len, 8'd0, ST_OK, m_pos);
            hit  = 1'b1;
            done = 1'b1;
         end
         default: ;
      endcase
      if (is_last)
         clear_parser();
      else if (done)
         m_phase = PH_DONE;
      return hit;
   endfunction

   // ---------------------------------------------------------------- record side
   function automatic void check_field(input string fname, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h",
                  $time, fname, want, got);
         n_err++;
      end
   endfunction

   task automatic check_record();
      record_type want;
      if (pending_records.size() == 0) begin
         $display("%0t: unexpected record: expected none, actual tuser=%0d tdata=0x%08h",
                  $time, rsp_tuser, rsp_tdata);
         n_err++;
      end else begin
         want = pending_records.pop_front();
         check_field("kind", 8'(want.kind), 8'(rsp_tuser));
         check_field("value", want.value, rsp_tdata[7:0]);
         check_field("field_index", want.field_index, rsp_tdata[15:8]);
         check_field("status", 8'(want.status), 8'(rsp_tdata[18:16]));
         check_field("consumed", want.consumed, rsp_tdata[26:19]);
         if (want.kind == KIND_ACCEPT)
            n_accept++;
         else if (want.kind == KIND_ERROR)
            n_error++;
         else
            n_field++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_record();
      if (hold_reqs != hold_seen) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // ---------------------------------------------------------------- request side
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      record_type rec;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (parse_byte(b, is_last, rec))
         pending_records.push_back(rec);
      n_sent++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < rx_buf.size(); i++)
         send_byte(rx_buf[i], i == rx_buf.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_delims(input logic [7:0] s, input logic [7:0] e);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_START;
      csr_wdata <= s;
      @(posedge clock);
      csr_addr  <= CSR_END;
      csr_wdata <= e;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_start = s;
      cfg_end   = e;
   endtask

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == cfg_start);
      return b;
   endfunction

   task automatic build_frame(input int lead, input int dlen, input bit bad_s2,
                              input bit bad_cs, input bit bad_end, input int trail);
      logic [7:0] cs;
      rx_buf.delete();
      repeat (lead) rx_buf.push_back(noise_byte());
      rx_buf.push_back(cfg_start);
      repeat (6) rx_buf.push_back(8'($urandom));
      rx_buf.push_back(bad_s2 ? cfg_start ^ 8'($urandom_range(1, 255)) : cfg_start);
      rx_buf.push_back(8'($urandom));
      rx_buf.push_back(8'(dlen));
      repeat (dlen) rx_buf.push_back(8'($urandom));
      cs = '0;
      for (int i = lead; i < rx_buf.size(); i++)
         cs += rx_buf[i];
      rx_buf.push_back(bad_cs ? cs ^ 8'($urandom_range(1, 255)) : cs);
      rx_buf.push_back(bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
      repeat (trail) rx_buf.push_back(8'($urandom));
   endtask

   task automatic send_random_buffer();
      int dlen;
      int cut;
      if ($urandom_range(99) < 12) begin
         rx_buf.delete();
         repeat ($urandom_range(1, 8)) rx_buf.push_back(8'($urandom));
      end else begin
         dlen = $urandom_range(0, 10);
         if ($urandom_range(49) == 0)
            dlen = $urandom_range(1) ? 255 : $urandom_range(11, 254);
         build_frame($urandom_range(0, 3), dlen, $urandom_range(99) < 8,
                     $urandom_range(99) < 15, $urandom_range(99) < 15,
                     $urandom_range(0, 3));
         if ($urandom_range(99) < 12) begin
            cut = $urandom_range(1, rx_buf.size() - 1);
            while (rx_buf.size() > cut)
               void'(rx_buf.pop_back());
         end
      end
      send_buffer();
      // now and then, hold the sender until every record is back
      if ($urandom_range(99) < 3)
         wait_drained();
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      build_frame(0, 0, 1'b0, 1'b0, 1'b0, 0);
      send_buffer();
      rx_buf = '{START_RESET};
      send_buffer();
      rx_buf = '{8'h00, 8'hFF};
      send_buffer();
      build_frame(0, 0, 1'b1, 1'b0, 1'b0, 0);
      while (rx_buf.size() > 8)
         void'(rx_buf.pop_back());
      send_buffer();
      wait_drained();
   endtask

   task automatic test_random_frames(input int n_items, input logic [7:0] s,
                                     input logic [7:0] e);
      int target;
      wait_drained();
      set_delims(s, e);
      target = n_sent + n_items;
      while (n_sent < target)
         send_random_buffer();
      wait_drained();
   endtask

   task automatic test_no_idle(input int n_items);
      src_idle_pct = 0;
      snk_idle_pct = 0;
      test_random_frames(n_items, 8'h16, 8'h16);
      src_idle_pct = 18;
      snk_idle_pct = 18;
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_reqs++;
      build_frame(1, 40, 1'b0, 1'b0, 1'b0, 2);
      send_buffer();
      wait_drained();
   endtask

   initial begin
      clear_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_frames(300, START_RESET, END_RESET);
      test_random_frames(300, 8'h00, 8'hFF);
      test_random_frames(300, 8'hFF, 8'h00);
      test_no_idle(300);
      test_backpressure();
      repeat (3) test_random_frames(150, 8'($urandom), 8'($urandom));
      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_records.size() != 0) begin
         $display("%0t: %0d expected records never arrived", $time, pending_records.size());
         n_err++;
      end
      $display("Sent %0d buffer bytes over several delimiter settings, idle and stall mixes",
               n_sent);
      $display("Checked %0d field, %0d accept and %0d error records; %0d mismatches",
               n_field, n_accept, n_error, n_err);
      if (n_err == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
